>>> sv/pdt_pkg.sv
// Shared types, codes and helper functions for the proof deadline table.
package pdt_pkg;

	// Input action codes
	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_TAKE  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	// Result kind codes
	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_HIT      = 3'd1,
		KIND_MISS     = 3'd2,
		KIND_EXPIRED  = 3'd3,
		KIND_DONE     = 3'd4,
		KIND_CLEARED  = 3'd5
	} kind_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

	// One table entry as held in the slot memory
	typedef struct packed {
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] dest_hi;
		logic [63:0] dest_lo;
		logic        long_range;
		logic        counted;
		logic [31:0] deadline;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;    // input transfer: latch item, rewind scan
		logic clear_all;  // drop every entry
		logic step;       // advance the slot scan by one
		logic free_s1;    // free the slot under evaluation
		logic emit_entry; // send the evaluated slot's data
		logic emit_fin;   // send the closing result
		logic write_en;   // store the new entry
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		action_t act;
		logic    has_free;
		logic    s1_vld;
		logic    s1_last;
		logic    s1_hit;
		logic    s1_expire;
		logic    s1_counted;
		logic    out_free;
	} sts_t;

	// a strictly later than b, wrap-aware
	function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

	// deadline reached at time now
	function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
		logic [31:0] d;
		d = now - dl;
		return !d[31];
	endfunction

endpackage

>>> sv/pdt_ctrl.sv
// Control state machine: sequences add, take, tick and clear over the slot scan.
module pdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      action,
	input  pdt_pkg::sts_t   sts,
	output pdt_pkg::cmd_t   cmd
);
	import pdt_pkg::*;

	state_t state_q, state_d;
	logic   need_emit;
	logic   is_take, is_tick;

	assign is_take   = (sts.act == ACT_TAKE);
	assign is_tick   = (sts.act == ACT_TICK);
	// evaluated slot has a result to send
	assign need_emit = sts.s1_vld &&
		((is_take && sts.s1_hit) || (is_tick && sts.s1_expire && sts.s1_counted));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (action_t'(action))
						ACT_ADD:   state_d = sts.has_free ? ST_WRITE : ST_SCAN;
						ACT_CLEAR: state_d = ST_FINISH;
						default:   state_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				if (!(need_emit && !sts.out_free)) begin
					if (sts.s1_vld && is_take && sts.s1_hit) begin
						state_d = ST_IDLE;
					end else if (sts.s1_vld && sts.s1_last) begin
						state_d = (sts.act == ACT_ADD) ? ST_WRITE : ST_FINISH;
					end
				end
			end
			ST_WRITE: state_d = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.load_in   = in_valid;
				cmd.clear_all = in_valid && (action_t'(action) == ACT_CLEAR);
			end
			ST_SCAN: begin
				if (!(need_emit && !sts.out_free)) begin
					if (sts.s1_vld && is_take && sts.s1_hit) begin
						cmd.emit_entry = 1'b1;
						cmd.free_s1    = 1'b1;
					end else begin
						cmd.step = 1'b1;
						if (sts.s1_vld && is_tick && sts.s1_expire) begin
							cmd.free_s1    = 1'b1;
							cmd.emit_entry = sts.s1_counted;
						end
					end
				end
			end
			ST_WRITE:  cmd.write_en = 1'b1;
			ST_FINISH: cmd.emit_fin = sts.out_free;
			default: ;
		endcase
	end

endmodule

>>> sv/pdt_dpath.sv
// Datapath: slot memory, used bits, scan stage, victim tracking, result register.
module pdt_dpath #(
	parameter int PEND_SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pdt_pkg::cmd_t   cmd,
	output pdt_pkg::sts_t   sts,
	input  logic            cfg_wr,
	input  logic [31:0]     proof_timeout_ms,
	input  logic [1:0]      action,
	input  logic [63:0]     key_hi,
	input  logic [63:0]     key_lo,
	input  logic [63:0]     dest_hi,
	input  logic [63:0]     dest_lo,
	input  logic            is_long_range,
	input  logic            is_counted,
	input  logic [31:0]     now_ms,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      kind,
	output logic [63:0]     out_dest_hi,
	output logic [63:0]     out_dest_lo,
	output logic            out_long_range,
	output logic            out_counted,
	output logic            last
);
	import pdt_pkg::*;

	localparam int IW = (PEND_SLOTS > 1) ? $clog2(PEND_SLOTS) : 1;
	localparam int CW = $clog2(PEND_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(PEND_SLOTS - 1);
	localparam logic [CW-1:0] NUM_SLOTS = CW'(PEND_SLOTS);

	// configuration and latched item
	logic [31:0]     timeout_q;
	action_t         act_q;
	logic [63:0]     key_hi_q, key_lo_q, dest_hi_q, dest_lo_q;
	logic            lr_q, cnt_q;
	logic [31:0]     now_q;

	// table state
	entry_t          slot_mem [PEND_SLOTS];
	logic [PEND_SLOTS-1:0] used_q;

	// scan address and evaluation stage
	logic [CW-1:0]   idx_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	entry_t          ent_s1;

	// earliest-deadline victim
	logic            victim_vld_q;
	logic [IW-1:0]   victim_q;
	logic [31:0]     victim_dl_q;

	// result register
	logic            out_vld_q;
	kind_t           kind_q;
	logic [63:0]     dest_hi_q2, dest_lo_q2;
	logic            lr_out_q, cnt_out_q, last_q;

	logic            has_free;
	logic [IW-1:0]   first_free;
	logic [IW-1:0]   wr_idx;
	logic            room;
	logic            s1_used;
	kind_t           fin_kind;
	entry_t          new_ent;

	// lowest free slot
	always_comb begin
		first_free = '0;
		for (int i = PEND_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) first_free = IW'(i);
		end
	end
	assign has_free = ~&used_q;
	assign wr_idx   = has_free ? first_free : victim_q;
	assign room     = (idx_q < NUM_SLOTS);
	assign s1_used  = used_q[idx_s1];

	// status back to the controller
	assign sts.act        = act_q;
	assign sts.has_free   = has_free;
	assign sts.s1_vld     = vld_s1;
	assign sts.s1_last    = (idx_s1 == LAST_IDX);
	assign sts.s1_hit     = s1_used && (ent_s1.key_hi == key_hi_q) && (ent_s1.key_lo == key_lo_q);
	assign sts.s1_expire  = s1_used && reached(now_q, ent_s1.deadline);
	assign sts.s1_counted = ent_s1.counted;
	assign sts.out_free   = !out_vld_q || !out_stall;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr) begin
			timeout_q <= proof_timeout_ms;
		end
	end

	// item latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_ADD;
		end else if (cmd.load_in) begin
			act_q <= action_t'(action);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_hi_q  <= key_hi;
			key_lo_q  <= key_lo;
			dest_hi_q <= dest_hi;
			dest_lo_q <= dest_lo;
			lr_q      <= is_long_range;
			cnt_q     <= is_counted;
			now_q     <= now_ms;
		end
	end

	// new entry for an add
	always_comb begin
		new_ent.key_hi     = key_hi_q;
		new_ent.key_lo     = key_lo_q;
		new_ent.dest_hi    = dest_hi_q;
		new_ent.dest_lo    = dest_lo_q;
		new_ent.long_range = lr_q;
		new_ent.counted    = cnt_q;
		new_ent.deadline   = now_q + timeout_q;
	end

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.write_en) slot_mem[wr_idx] <= new_ent;
		if (cmd.step && room) ent_s1 <= slot_mem[idx_q[IW-1:0]];
		if (cmd.step) idx_s1 <= idx_q[IW-1:0];
	end

	// used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clear_all) begin
			used_q <= '0;
		end else begin
			if (cmd.write_en) used_q[wr_idx] <= 1'b1;
			if (cmd.free_s1) used_q[idx_s1] <= 1'b0;
		end
	end

	// scan counter and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.load_in) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.step) begin
			if (room) idx_q <= idx_q + CW'(1);
			vld_s1 <= room;
		end
	end

	// running earliest deadline, lowest slot on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_vld_q <= 1'b0;
		end else if (cmd.load_in) begin
			victim_vld_q <= 1'b0;
		end else if (cmd.step && vld_s1 && (act_q == ACT_ADD)) begin
			victim_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && vld_s1 && (act_q == ACT_ADD) &&
		    (!victim_vld_q || later_than(victim_dl_q, ent_s1.deadline))) begin
			victim_q    <= idx_s1;
			victim_dl_q <= ent_s1.deadline;
		end
	end

	// closing result kind
	always_comb begin
		case (act_q)
			ACT_ADD:  fin_kind = KIND_ADDED;
			ACT_TAKE: fin_kind = KIND_MISS;
			ACT_TICK: fin_kind = KIND_DONE;
			default:  fin_kind = KIND_CLEARED;
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit_entry || cmd.emit_fin) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_entry) begin
			kind_q     <= (act_q == ACT_TAKE) ? KIND_HIT : KIND_EXPIRED;
			dest_hi_q2 <= ent_s1.dest_hi;
			dest_lo_q2 <= ent_s1.dest_lo;
			lr_out_q   <= ent_s1.long_range;
			cnt_out_q  <= ent_s1.counted;
			last_q     <= (act_q == ACT_TAKE);
		end else if (cmd.emit_fin) begin
			kind_q     <= fin_kind;
			dest_hi_q2 <= '0;
			dest_lo_q2 <= '0;
			lr_out_q   <= 1'b0;
			cnt_out_q  <= 1'b0;
			last_q     <= 1'b1;
		end
	end

	assign out_valid      = out_vld_q;
	assign kind           = kind_q;
	assign out_dest_hi    = dest_hi_q2;
	assign out_dest_lo    = dest_lo_q2;
	assign out_long_range = lr_out_q;
	assign out_counted    = cnt_out_q;
	assign last           = last_q;

endmodule

>>> sv/proof_deadline_table_core.sv
// Top level: table of pending proof deadlines with earliest-deadline eviction.
// An add with a free slot goes from idle to the write state, then to finish. A clear goes to finish.
// Take and tick scan the slot memory one slot a cycle while no output stall holds the scan
// (one read port, registered read); a take hit ends the scan early, and an add into a full
// table scans every slot to pick its victim first. One item in work at a time.
// Reset clears all used bits and loads the timeout with 30000; no clearing pass.
module proof_deadline_table_core #(
	parameter int PEND_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] proof_timeout_ms,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	input  logic [63:0] dest_hi,
	input  logic [63:0] dest_lo,
	input  logic        is_long_range,
	input  logic        is_counted,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [63:0] out_dest_hi,
	output logic [63:0] out_dest_lo,
	output logic        out_long_range,
	output logic        out_counted,
	output logic        last
);
	import pdt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// register write transfer always completes
	assign cfg_ready = 1'b1;

	pdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdt_dpath #(
		.PEND_SLOTS (PEND_SLOTS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr           (cfg_valid && cfg_ready),
		.proof_timeout_ms (proof_timeout_ms),
		.action           (action),
		.key_hi           (key_hi),
		.key_lo           (key_lo),
		.dest_hi          (dest_hi),
		.dest_lo          (dest_lo),
		.is_long_range    (is_long_range),
		.is_counted       (is_counted),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.out_dest_hi      (out_dest_hi),
		.out_dest_lo      (out_dest_lo),
		.out_long_range   (out_long_range),
		.out_counted      (out_counted),
		.last             (last)
	);

endmodule
